/* sv/srt_pkg.sv */
// Package with shared constants and types for the sorted record table.
`default_nettype none
package srt_pkg;
  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SRCH_ID = 2'd2;
  localparam logic [1:0] OP_SRCH_PTS = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic shift_up;
    logic shift_down;
    logic write_new;
    logic cnt_inc;
    logic cnt_dec;
  } srt_cmd_t;

  typedef struct packed {
    logic hit;
    logic less;
    logic [IdxW-1:0] idx;
    logic idx_at_end;
    logic [CntW-1:0] count;
  } srt_stat_t;
endpackage
`default_nettype wire

/* sv/sorted_record_table.sv */
// Top level of the sorted record table.
// Each command is driven by a single scan index over the record memory: insert scans
// once for a duplicate and again for its position, delete until it finds the record,
// and a search counts matches in a pass, then streams them in a second. Every result
// word appears for one cycle with out_valid and cannot be stalled; out_last marks
// the final word of a command, and busy is low again when the next command may start.
`default_nettype none
module sorted_record_table import srt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_operation,
  input  wire logic [30:0] in_record_id,
  input  wire logic [15:0] in_points,
  input  wire logic [31:0] in_payload,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [4:0] out_position,
  output logic [5:0] out_match_number,
  output logic [5:0] out_entry_count,
  output logic out_last
);
  srt_cmd_t cmd;
  srt_stat_t stat;
  logic [IdxW-1:0] wr_idx;

  srt_control u_ctrl (
    .clk, .rst_n, .start, .in_operation, .stat, .cmd, .wr_idx, .busy,
    .out_valid, .out_status, .out_position, .out_match_number,
    .out_entry_count, .out_last
  );

  srt_datapath u_dp (
    .clk, .rst_n, .in_operation, .in_record_id, .in_points, .in_payload,
    .cmd, .wr_idx, .stat
  );
endmodule
`default_nettype wire

/* sv/srt_datapath.sv */
// Datapath holding the record memory, the scan index and the record count.
`default_nettype none
module srt_datapath import srt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [1:0] in_operation,
  input  wire logic [30:0] in_record_id,
  input  wire logic [15:0] in_points,
  input  wire logic [31:0] in_payload,
  input  wire srt_cmd_t cmd,
  input  wire logic [IdxW-1:0] wr_idx,
  output srt_stat_t stat
);
  logic [30:0] ids_r [Capacity];
  logic [15:0] pts_r [Capacity];
  logic [31:0] pay_r [Capacity];
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] idx_r;
  logic [1:0] op_r;
  logic [30:0] id_r;
  logic [15:0] key_pts_r;
  logic [31:0] key_pay_r;
  logic [IdxW-1:0] rd_idx;
  logic [30:0] id_rd;
  logic [15:0] pts_rd;

  assign rd_idx = idx_r[IdxW-1:0];
  assign id_rd = ids_r[rd_idx];
  assign pts_rd = pts_r[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      id_r <= in_record_id;
      key_pts_r <= in_points;
      key_pay_r <= in_payload;
    end
    for (int k = 0; k < Capacity; k++) begin
      if (cmd.shift_up && k > 0 && IdxW'(k) > wr_idx && CntW'(k) <= count_r) begin
        ids_r[k] <= ids_r[k-1];
        pts_r[k] <= pts_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end else if (cmd.shift_down && k < Capacity - 1 && IdxW'(k) >= wr_idx) begin
        ids_r[k] <= ids_r[k+1];
        pts_r[k] <= pts_r[k+1];
        pay_r[k] <= pay_r[k+1];
      end
    end
    if (cmd.write_new) begin
      ids_r[wr_idx] <= id_r;
      pts_r[wr_idx] <= key_pts_r;
      pay_r[wr_idx] <= key_pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.cnt_inc) count_r <= count_r + 1'b1;
      else if (cmd.cnt_dec) count_r <= count_r - 1'b1;
      if (cmd.scan_start) idx_r <= '0;
      else if (cmd.scan_step) idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    stat.hit = (op_r == OP_SRCH_PTS) ? (pts_rd == key_pts_r) : (id_rd == id_r);
    stat.less = id_rd < id_r;
    stat.idx = idx_r[IdxW-1:0];
    stat.idx_at_end = (idx_r >= count_r) || (count_r == '0);
    stat.count = count_r;
  end
endmodule
`default_nettype wire

/* sv/srt_control.sv */
// Controller state machine sequencing scans, shifts and result strobes.
`default_nettype none
module srt_control import srt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [1:0] in_operation,
  input  wire srt_stat_t stat,
  output srt_cmd_t cmd,
  output logic [IdxW-1:0] wr_idx,
  output logic busy,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [4:0] out_position,
  output logic [5:0] out_match_number,
  output logic [5:0] out_entry_count,
  output logic out_last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DUP = 3'd1;
  localparam logic [2:0] S_POS = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_CNT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_SCAN = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r;
  logic [IdxW-1:0] at_r, at_nxt;
  logic [CntW-1:0] total_r, total_nxt;
  logic [CntW-1:0] nmatch_r, nmatch_nxt;
  logic [1:0] st_r, st_nxt;
  logic ov_nxt, last_nxt;
  logic [4:0] pos_nxt;
  logic [5:0] mn_nxt;
  logic [CntW-1:0] cnt_after;

  assign busy = (state_r != S_IDLE);
  assign wr_idx = at_r;

  always_comb begin
    state_nxt = state_r;
    at_nxt = at_r;
    total_nxt = total_r;
    nmatch_nxt = nmatch_r;
    st_nxt = st_r;
    cmd = '0;
    ov_nxt = 1'b0;
    last_nxt = 1'b1;
    pos_nxt = '0;
    mn_nxt = '0;
    cnt_after = stat.count;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          total_nxt = '0;
          nmatch_nxt = '0;
          at_nxt = '0;
          state_nxt = (in_operation == OP_INSERT || in_operation == OP_DELETE) ? S_DUP : S_CNT;
        end
      end
      S_DUP: begin
        if (stat.idx_at_end) begin
          cmd.scan_start = 1'b1;
          if (op_r == OP_DELETE) begin
            ov_nxt = 1'b1;
            st_nxt = ST_NOTFOUND;
            state_nxt = S_IDLE;
          end else if (CntW'(stat.count) >= CntW'(Capacity)) begin
            ov_nxt = 1'b1;
            st_nxt = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_POS;
          end
        end else if (stat.hit) begin
          if (op_r == OP_DELETE) begin
            at_nxt = stat.idx;
            state_nxt = S_MOVE;
          end else begin
            ov_nxt = 1'b1;
            st_nxt = ST_DUP;
            pos_nxt = 5'(stat.idx);
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_POS: begin
        if (!stat.idx_at_end && stat.less) begin
          cmd.scan_step = 1'b1;
        end else begin
          at_nxt = stat.idx;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        st_nxt = ST_OK;
        ov_nxt = 1'b1;
        pos_nxt = 5'(at_r);
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          cmd.shift_up = 1'b1;
          cmd.write_new = 1'b1;
          cmd.cnt_inc = 1'b1;
          cnt_after = stat.count + 1'b1;
        end else begin
          cmd.shift_down = 1'b1;
          cmd.cnt_dec = 1'b1;
          cnt_after = stat.count - 1'b1;
        end
      end
      S_CNT: begin
        if (stat.idx_at_end) begin
          cmd.scan_start = 1'b1;
          if (total_r == '0) begin
            ov_nxt = 1'b1;
            st_nxt = ST_NOTFOUND;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.hit) total_nxt = total_r + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          nmatch_nxt = nmatch_r + 1'b1;
          ov_nxt = 1'b1;
          st_nxt = ST_OK;
          pos_nxt = 5'(stat.idx);
          mn_nxt = 6'(nmatch_nxt);
          last_nxt = (nmatch_nxt == total_r);
          if (last_nxt) state_nxt = S_IDLE;
        end
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) op_r <= in_operation;
    at_r <= at_nxt;
    total_r <= total_nxt;
    nmatch_r <= nmatch_nxt;
    st_r <= st_nxt;
    out_status <= st_nxt;
    out_position <= pos_nxt;
    out_match_number <= mn_nxt;
    out_entry_count <= 6'(cnt_after);
    out_last <= last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |=> !busy) else $error("idle left without start");
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (stat.count < CntW'(Capacity))) else $error("count overflow");
  a_no_udf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (stat.count != '0)) else $error("count underflow");
`endif
endmodule
`default_nettype wire
